/* hdl/pointer_velocity_filter_top_macros.svh */
// Assertion macros for the pointer velocity filter checker.
// Needs signals clk and rst in the scope of use.
`ifndef POINTER_VELOCITY_FILTER_TOP_MACROS_SVH
`define POINTER_VELOCITY_FILTER_TOP_MACROS_SVH

// Implication to the next cycle, held off during reset
`define PVF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pointer velocity filter check failed");

// Condition that holds in every cycle out of reset
`define PVF_ASSERT_ALWAYS(lbl, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cons)) \
    else $error("pointer velocity filter check failed");

// Condition that holds in the cycle after reset
`define PVF_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pointer velocity filter reset check failed");

`endif

/* hdl/pvf_pkg.sv */
// Shared types and constants of the pointer velocity filter.
// No dependencies.
package pvf_pkg;

  localparam int TIME_W = 32;
  localparam int POS_W  = 20;
  localparam int VEL_W  = 32;
  localparam int DIVD_W = 36;
  localparam int DIVS_W = 32;
  localparam int CNT_W  = 6;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd50;
  localparam logic [DIVS_W-1:0] WEIGHT_DIV    = 32'd5;

  localparam logic [2:0] KIND_DOWN  = 3'd0;
  localparam logic [2:0] KIND_MOVE  = 3'd1;
  localparam logic [2:0] KIND_UP    = 3'd2;
  localparam logic [2:0] KIND_QUERY = 3'd4;

  typedef enum logic [3:0] {
    OP_DOWN  = 4'b0001,
    OP_TRACK = 4'b0010,
    OP_CLEAR = 4'b0100,
    OP_QUERY = 4'b1000
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [TIME_W-1:0]       time_stamp;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage

/* hdl/pvf_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on pvf_pkg.
module pvf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pvf_pkg::DIVD_W-1:0]  dividend,
  input  logic [pvf_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [pvf_pkg::DIVD_W-1:0]  quotient
);
  import pvf_pkg::*;

  logic [DIVS_W:0]   rem;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [DIVS_W:0]   rem_sh;
  logic              ge;

  assign rem_sh   = {rem[DIVS_W-1:0], quo[DIVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIVD_W - 1);
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
      end else if (run) begin
        rem <= ge ? rem_sh - {1'b0, dsr} : rem_sh;
        quo <= {quo[DIVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/pvf_front.sv */
// Input side: decode requests and hold them in a two-entry queue.
// Depends on pvf_pkg.
module pvf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,  // time_stamp[31:0], pos_x[51:32], pos_y[71:52]
  input  logic [2:0]           s_axis_tuser,  // kind[2:0]
  output pvf_pkg::queue_t      q,
  input  logic                 q_pop
);
  import pvf_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      in_item;

  always_comb begin
    unique case (s_axis_tuser) inside
      KIND_DOWN:          in_item.op = OP_DOWN;
      KIND_MOVE, KIND_UP: in_item.op = OP_TRACK;
      KIND_QUERY:         in_item.op = OP_QUERY;
      default:            in_item.op = OP_CLEAR;
    endcase
    in_item.time_stamp = s_axis_tdata[31:0];
    in_item.pos_x      = s_axis_tdata[51:32];
    in_item.pos_y      = s_axis_tdata[71:52];
  end

  assign s_axis_tready = count != 2'd2;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop && (count != 2'd0);
  assign q.valid       = count != 2'd0;
  assign q.item        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/pvf_back.sv */
// Execution side: track state, pair velocity and filter merge.
// Depends on pvf_pkg and pvf_div.
module pvf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  pvf_pkg::queue_t              q,
  output logic                         q_pop,
  input  logic                         cfg_valid,
  input  logic [31:0]                  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pvf_pkg::VEL_W-1:0]    out_x,
  output logic [pvf_pkg::VEL_W-1:0]    out_y
);
  import pvf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_VDIV = 4'b0010,
    ST_PREP = 4'b0100,
    ST_WDIV = 4'b1000
  } state_t;

  state_t                  state;
  logic [TIME_W-1:0]       timeout;
  logic [TIME_W-1:0]       last_time;
  logic                    pvalid;
  logic [TIME_W-1:0]       ptime;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic [VEL_W-1:0]        pair_x, pair_y, filt_x, filt_y, cur_x, cur_y;
  logic [VEL_W-1:0]        alt_x, alt_y;
  logic                    use_w_x, use_w_y, neg_x, neg_y;
  logic                    multi;
  logic [DIVD_W-1:0]       wq_x, wq_y, wn_x, wn_y;
  logic [2:0]              wstep;

  item_t               it;
  logic [TIME_W-1:0]   base;
  logic                expired;
  logic                stale;
  logic signed [POS_W:0] dx, dy;
  logic [POS_W:0]      mag_x, mag_y;
  logic [TIME_W-1:0]   dt;
  logic                div_start;
  logic [DIVD_W-1:0]   dvd_x, dvd_y;
  logic [DIVS_W-1:0]   dvs;
  logic                done_x, done_y;
  logic [DIVD_W-1:0]   quo_x, quo_y;
  logic                wu_x, wu_y, sn_x, sn_y;
  logic [VEL_W-1:0]    al_x, al_y;
  logic [DIVD_W-1:0]   wd_x, wd_y;
  logic [DIVD_W-1:0]   fq_x, fq_y;

  function automatic logic [VEL_W-1:0] sat_add(input logic [VEL_W-1:0] a,
                                                input logic [VEL_W-1:0] b);
    logic [VEL_W:0] s;
    s = {a[VEL_W-1], a} + {b[VEL_W-1], b};
    if (s[VEL_W] != s[VEL_W-1]) begin
      return s[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end
    return s[VEL_W-1:0];
  endfunction

  // Finish a divide by five: correct a shift-and-add estimate that falls short by up to three
  function automatic logic [DIVD_W-1:0] fix5(input logic [DIVD_W-1:0] n,
                                             input logic [DIVD_W-1:0] est);
    logic [DIVD_W-1:0] r;
    r = n - ((est << 2) + est);
    return est + DIVD_W'(r >= DIVD_W'(WEIGHT_DIV)) + DIVD_W'(r >= DIVD_W'(2 * WEIGHT_DIV))
         + DIVD_W'(r >= DIVD_W'(3 * WEIGHT_DIV));
  endfunction

  // Decide the merge of one axis; weighted sums go to the divider as |2a+3b|+2
  function automatic void plan(input  logic [VEL_W-1:0] prev,
                               input  logic [VEL_W-1:0] acc,
                               input  logic [VEL_W-1:0] cur,
                               output logic             use_w,
                               output logic             s_neg,
                               output logic [VEL_W-1:0] alt,
                               output logic [DIVD_W-1:0] dvd);
    logic             acc_neg, acc_pos, cur_neg, cur_pos, prv_neg, prv_pos;
    logic [VEL_W-1:0] a;
    logic [VEL_W+2:0] s;
    logic [VEL_W+2:0] mag;
    acc_neg = acc[VEL_W-1];
    acc_pos = !acc[VEL_W-1] && (acc != '0);
    cur_neg = cur[VEL_W-1];
    cur_pos = !cur[VEL_W-1] && (cur != '0);
    prv_neg = prev[VEL_W-1];
    prv_pos = !prev[VEL_W-1] && (prev != '0);
    use_w   = 1'b1;
    alt     = cur;
    a       = acc;
    if (acc == '0) begin
      use_w = 1'b0;
    end else if ((acc_neg && cur_pos) || (acc_pos && cur_neg)) begin
      if ((prv_pos && cur_pos) || (prv_neg && cur_neg)) begin
        a = prev;
      end else begin
        use_w = 1'b0;
        alt   = sat_add(acc, cur);
      end
    end
    s     = {{2{a[VEL_W-1]}}, a, 1'b0} + {{3{cur[VEL_W-1]}}, cur}
          + {{2{cur[VEL_W-1]}}, cur, 1'b0};
    s_neg = s[VEL_W+2];
    mag   = s_neg ? -s : s;
    dvd   = DIVD_W'(mag) + DIVD_W'(2);
  endfunction

  assign it      = q.item;
  assign base    = (it.op == OP_DOWN) ? it.time_stamp : last_time;
  assign expired = (it.time_stamp >= base) && ((it.time_stamp - base) >= timeout);
  assign stale   = it.time_stamp <= ptime;
  assign dx      = {it.pos_x[POS_W-1], it.pos_x} - {px[POS_W-1], px};
  assign dy      = {it.pos_y[POS_W-1], it.pos_y} - {py[POS_W-1], py};
  assign mag_x   = dx[POS_W] ? -dx : dx;
  assign mag_y   = dy[POS_W] ? -dy : dy;
  assign dt      = it.time_stamp - ptime;
  assign dvd_x   = DIVD_W'({mag_x, 8'd0});
  assign dvd_y   = DIVD_W'({mag_y, 8'd0});
  assign dvs     = dt;
  assign fq_x    = fix5(wn_x, wq_x);
  assign fq_y    = fix5(wn_y, wq_y);

  always_comb begin
    plan(pair_x, filt_x, cur_x, wu_x, sn_x, al_x, wd_x);
    plan(pair_y, filt_y, cur_y, wu_y, sn_y, al_y, wd_y);
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q.valid) begin
          if (it.op == OP_QUERY) begin
            q_pop = !out_valid || out_ready;
          end else begin
            q_pop = 1'b1;
            div_start = (it.op != OP_CLEAR) && pvalid && !expired && !stale;
          end
        end
      end
      ST_VDIV, ST_PREP, ST_WDIV: begin
      end
      default: begin
      end
    endcase
  end

  pvf_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd_x), .divisor(dvs),
    .done(done_x), .quotient(quo_x)
  );

  pvf_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd_y), .divisor(dvs),
    .done(done_y), .quotient(quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      timeout   <= TIMEOUT_RESET;
      last_time <= '0;
      pvalid    <= 1'b0;
      ptime     <= '0;
      px        <= '0;
      py        <= '0;
      pair_x    <= '0;
      pair_y    <= '0;
      filt_x    <= '0;
      filt_y    <= '0;
      multi     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (it.op)
              OP_QUERY: begin
                out_valid <= 1'b1;
                out_x     <= filt_x;
                out_y     <= filt_y;
                if (multi) begin
                  pvalid <= 1'b0;
                  pair_x <= '0;
                  pair_y <= '0;
                  multi  <= 1'b0;
                end
              end
              OP_CLEAR: begin
                pvalid <= 1'b0;
                pair_x <= '0;
                pair_y <= '0;
                filt_x <= '0;
                filt_y <= '0;
                multi  <= 1'b0;
              end
              OP_DOWN, OP_TRACK: begin
                last_time <= it.time_stamp;
                if (expired) begin
                  pair_x <= '0;
                  pair_y <= '0;
                  filt_x <= '0;
                  filt_y <= '0;
                  multi  <= 1'b0;
                end
                if (!pvalid || expired || !stale) begin
                  pvalid <= 1'b1;
                  ptime  <= it.time_stamp;
                  px     <= it.pos_x;
                  py     <= it.pos_y;
                end
                if (div_start) begin
                  neg_x <= dx[POS_W];
                  neg_y <= dy[POS_W];
                  state <= ST_VDIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_VDIV: begin
          if (done_x && done_y) begin
            cur_x <= neg_x ? -quo_x[VEL_W-1:0] : quo_x[VEL_W-1:0];
            cur_y <= neg_y ? -quo_y[VEL_W-1:0] : quo_y[VEL_W-1:0];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          use_w_x <= wu_x;
          use_w_y <= wu_y;
          neg_x   <= sn_x;
          neg_y   <= sn_y;
          alt_x   <= al_x;
          alt_y   <= al_y;
          wn_x    <= wd_x;
          wn_y    <= wd_y;
          wq_x    <= (wd_x >> 1) + (wd_x >> 2);
          wq_y    <= (wd_y >> 1) + (wd_y >> 2);
          wstep   <= 3'd0;
          state   <= ST_WDIV;
        end
        ST_WDIV: begin
          wstep <= wstep + 3'd1;
          case (wstep)
            3'd0: begin
              wq_x <= wq_x + (wq_x >> 4);
              wq_y <= wq_y + (wq_y >> 4);
            end
            3'd1: begin
              wq_x <= wq_x + (wq_x >> 8);
              wq_y <= wq_y + (wq_y >> 8);
            end
            3'd2: begin
              wq_x <= wq_x + (wq_x >> 16);
              wq_y <= wq_y + (wq_y >> 16);
            end
            3'd3: begin
              wq_x <= wq_x + (wq_x >> 32);
              wq_y <= wq_y + (wq_y >> 32);
            end
            3'd4: begin
              wq_x <= wq_x >> 2;
              wq_y <= wq_y >> 2;
            end
            default: begin
              filt_x <= use_w_x ? (neg_x ? -fq_x[VEL_W-1:0] : fq_x[VEL_W-1:0]) : alt_x;
              filt_y <= use_w_y ? (neg_y ? -fq_y[VEL_W-1:0] : fq_y[VEL_W-1:0]) : alt_y;
              pair_x <= cur_x;
              pair_y <= cur_y;
              multi  <= 1'b1;
              state  <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/pointer_velocity_filter_top.sv */
// Pointer velocity filter: top level joining the request queue and the executor.
// Depends on pvf_pkg, pvf_front, pvf_back.
//
// Requests enter on s_axis: tuser carries the kind (down, move, up, cancel, query),
// tdata the time stamp and the x and y position. Only a query gives a response on
// m_axis, the filtered x and y velocity in position units per ms with 8 fraction bits.
// The inactivity timeout is written on the cfg channel, which is always ready.
// A two-entry queue takes requests while the executor is busy.
// Query, cancel, first point and skipped point are handled in the idle state alone; a
// query response is registered from the head of the queue.
// A point that forms a pair runs a 36-step restoring divider per axis for the pair
// velocity, then a shift-and-add divide by five for the 0.4/0.6 weighting.
// Reset empties the queue, drops any pending response, sets the timeout to 50 ms and
// clears all tracking state.
// A stalled m_axis holds the response; the next query waits at the head of the queue,
// requests ahead of it are still processed, and s_axis_tready drops once the queue fills.
module pointer_velocity_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // time_stamp[31:0], pos_x[51:32], pos_y[71:52]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // vel_x[31:0], vel_y[63:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import pvf_pkg::*;

  queue_t           q;
  logic             q_pop;
  logic [VEL_W-1:0] vel_x;
  logic [VEL_W-1:0] vel_y;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {vel_y, vel_x};

  pvf_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .q(q), .q_pop(q_pop)
  );

  pvf_back u_back (
    .clk(clk), .rst(rst), .q(q), .q_pop(q_pop),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_x(vel_x), .out_y(vel_y)
  );

endmodule

/* hdl/pvf_check.sv */
// Port-level checks of the pointer velocity filter, bound to the top level.
// Depends on pointer_velocity_filter_top_macros.svh.
`include "pointer_velocity_filter_top_macros.svh"
module pvf_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        cfg_ready
);
  `PVF_ASSERT_NEXT(a_resp_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PVF_ASSERT_NEXT(a_data_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `PVF_ASSERT_RESET(a_reset_empty, !m_axis_tvalid && s_axis_tready)
  `PVF_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)
endmodule

bind pointer_velocity_filter_top pvf_check u_check (.*);
